### design/utf16_to_utf8_transcoder_unit_macros.svh
// Assertion macros for the UTF-16 to UTF-8 transcoder checker.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define U16U8_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define U16U8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/u16u8_pkg.sv
package u16u8_pkg;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT  = 8'h80;

   localparam int MAX_BYTES = 6;

   typedef logic [2:0] cnt_type;

   // One request's worth of output bytes, first byte at index 0.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [MAX_BYTES-1:0]      repl;
      cnt_type                   count;
      logic                      last;
   } job_type;

endpackage

### design/u16u8_front.sv
module u16u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [15:0]       req_code_unit,
   input  logic              req_last_unit,
   output logic              push_valid,
   output u16u8_pkg::job_type push_job,
   input  logic              queue_full
);
   import u16u8_pkg::*;

   logic            pend_ff, pend_in;
   logic [9:0]      hi_ff;
   logic            is_high, is_low, join_pair, hold;
   logic [20:0]     enc_cp;
   logic [3:0][7:0] enc_b;
   cnt_type         enc_n;
   logic [2:0][7:0] fb;
   cnt_type         fn;
   logic [2:0]      frepl;
   job_type         job;
   logic            accept;

   always_comb begin
      is_high   = req_code_unit inside {[HIGH_FIRST:HIGH_LAST]};
      is_low    = req_code_unit inside {[LOW_FIRST:LOW_LAST]};
      join_pair = pend_ff && is_low;
      hold      = !join_pair && is_high && !req_last_unit;

      // supplementary point: held ten bits, low ten bits, plus 0x10000
      enc_cp = join_pair ? ({1'b0, hi_ff, req_code_unit[9:0]} + SUPP_BASE)
                         : {5'd0, req_code_unit};

      enc_b = '0;
      if (enc_cp <= 21'h7F) begin
         enc_b[0] = {1'b0, enc_cp[6:0]};
         enc_n    = 3'd1;
      end else if (enc_cp <= 21'h7FF) begin
         enc_b[0] = LEAD2 | {3'd0, enc_cp[10:6]};
         enc_b[1] = CONT | {2'd0, enc_cp[5:0]};
         enc_n    = 3'd2;
      end else if (enc_cp <= 21'hFFFF) begin
         enc_b[0] = LEAD3 | {4'd0, enc_cp[15:12]};
         enc_b[1] = CONT | {2'd0, enc_cp[11:6]};
         enc_b[2] = CONT | {2'd0, enc_cp[5:0]};
         enc_n    = 3'd3;
      end else begin
         enc_b[0] = LEAD4 | {5'd0, enc_cp[20:18]};
         enc_b[1] = CONT | {2'd0, enc_cp[17:12]};
         enc_b[2] = CONT | {2'd0, enc_cp[11:6]};
         enc_b[3] = CONT | {2'd0, enc_cp[5:0]};
         enc_n    = 3'd4;
      end

      // unit handled as if nothing were held
      if (hold) begin
         fb    = '0;
         fn    = 3'd0;
         frepl = 3'b000;
      end else if (is_high || is_low) begin
         fb    = {REPL_B2, REPL_B1, REPL_B0};
         fn    = 3'd3;
         frepl = 3'b111;
      end else begin
         fb    = enc_b[2:0];
         fn    = enc_n;
         frepl = 3'b000;
      end

      job      = '0;
      job.last = req_last_unit;
      if (join_pair) begin
         job.bytes[3:0] = enc_b;
         job.count      = 3'd4;
      end else if (pend_ff) begin
         // broken pair: replacement first, then the unit itself
         job.bytes[2:0] = {REPL_B2, REPL_B1, REPL_B0};
         job.bytes[5:3] = fb;
         job.repl       = {frepl, 3'b111};
         job.count      = 3'd3 + fn;
      end else begin
         job.bytes[2:0] = fb;
         job.repl[2:0]  = frepl;
         job.count      = fn;
      end

      accept     = req_valid && !queue_full;
      pend_in    = accept ? hold : pend_ff;
      req_ready  = !queue_full;
      push_valid = accept && (job.count != 3'd0);
      push_job   = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold) begin
         hi_ff <= req_code_unit[9:0];
      end
   end

endmodule

### design/u16u8_queue.sv
module u16u8_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   output logic               head_valid,
   output u16u8_pkg::job_type head_job,
   input  logic               pop
);
   import u16u8_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == CNT_W'(DEPTH));
      head_valid = (cnt_ff != '0);
      head_job   = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (push_valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push_valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/u16u8_back.sv
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  u16u8_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_string,
   output logic               rsp_is_replacement
);
   import u16u8_pkg::*;

   cnt_type    idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic       run_end_ff, eos_ff, repl_ff;
   logic       load, final_byte;

   always_comb begin
      load       = head_valid && (!rsp_valid_ff || rsp_ready);
      final_byte = (idx_ff == head_job.count - 3'd1);
      pop        = load && final_byte;

      idx_in = idx_ff;
      if (load) begin
         idx_in = final_byte ? 3'd0 : idx_ff + 3'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= head_job.bytes[idx_ff];
         run_end_ff <= final_byte;
         eos_ff     <= final_byte && head_job.last;
         repl_ff    <= head_job.repl[idx_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_last_of_run    = run_end_ff;
   assign rsp_end_of_string  = eos_ff;
   assign rsp_is_replacement = repl_ff;

endmodule

### design/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder.
// req channel: one UTF-16 code unit per request (req_code_unit) plus
//   req_last_unit marking the final unit of a string. valid/ready.
// rsp channel: one UTF-8 byte per transfer, with flags for the last byte
//   of the request's run, the last byte of the string, and membership in a
//   U+FFFD replacement. valid/ready.
// A request yields 0 to 6 bytes: a held high surrogate gives none until
//   its follower arrives; a broken pair gives EF BF BD and then the
//   follower's own bytes.
// Front classifies and encodes a request combinationally and writes the whole
//   byte group into a QUEUE_DEPTH-entry queue; back drains the head entry
//   one byte per cycle, while rsp is not stalled, into the rsp output register.
// A taken request's first byte passes the queue entry, then the rsp output register.
// Throughput: one rsp byte per cycle while rsp is not stalled, set by the single
//   back-end output register; a request yields up to 6 bytes. req_ready drops
//   only while the queue is full.
// Reset: synchronous, clears the held surrogate, the queue and rsp_valid.
// A stalled receiver holds the rsp byte steady; the queue keeps taking
//   requests until it fills.
module utf16_to_utf8_transcoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_string,
   output logic        rsp_is_replacement
);
   import u16u8_pkg::*;

   logic    push_valid, queue_full, head_valid, pop;
   job_type push_job, head_job;

   // classify, hold surrogates, build the byte group
   u16u8_front front_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .push_valid    (push_valid),
      .push_job      (push_job),
      .queue_full    (queue_full)
   );

   // decouples the front from rsp back-pressure
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue_inst (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // serialize bytes into the output register
   u16u8_back back_inst (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_job           (head_job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_string  (rsp_end_of_string),
      .rsp_is_replacement (rsp_is_replacement)
   );

endmodule

### design/u16u8_checker.sv
`include "utf16_to_utf8_transcoder_unit_macros.svh"

module u16u8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last_of_run,
   input logic        rsp_end_of_string,
   input logic        rsp_is_replacement
);

   // stalled byte holds
   `U16U8_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run)
      && $stable(rsp_end_of_string) && $stable(rsp_is_replacement),
      "rsp changed while stalled")

   // nothing comes out right after reset
   `U16U8_ASSERT_IMPLY(rsp_reset_a, clock, 1'b0, !reset && $past(reset), !rsp_valid,
      "rsp_valid after reset")

   // string end is always a run end
   `U16U8_ASSERT_IMPLY(rsp_eos_a, clock, reset, rsp_valid && rsp_end_of_string,
      rsp_last_of_run, "end_of_string without last_of_run")

   // replacement bytes are EF, BF or BD
   `U16U8_ASSERT_IMPLY(rsp_repl_a, clock, reset, rsp_valid && rsp_is_replacement,
      rsp_out_byte == 8'hEF || rsp_out_byte == 8'hBF || rsp_out_byte == 8'hBD,
      "bad replacement byte")

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker checker_inst (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_last_of_run    (rsp_last_of_run),
   .rsp_end_of_string  (rsp_end_of_string),
   .rsp_is_replacement (rsp_is_replacement)
);
